>>> rtl/core/tpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_pkg
// Types and constants shared by the two-level page table engine and its
// port checker.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Address split: 10-bit directory index, 10-bit table index, 12-bit offset
  localparam int VA_W       = 32;
  localparam int OFFSET_W   = 12;
  localparam int DIR_IDX_W  = 10;
  localparam int TBL_IDX_W  = 10;
  localparam int SLOT_W     = DIR_IDX_W + TBL_IDX_W;
  localparam int FRAME_W    = VA_W - OFFSET_W;

  // Stored words
  localparam int DIR_W      = 2;   // bit0 present, bit1 user
  localparam int ENTRY_W    = 32;  // frame in 31:12, flags in 11:0
  localparam int FLAG_W     = 12;

  localparam int DIR_PRESENT_BIT  = 0;
  localparam int DIR_USER_BIT     = 1;
  localparam int FLAG_PRESENT_BIT = 0;
  localparam int FLAG_USER_BIT    = 2;

  // Stream widths (padded to whole bytes)
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  // Input field positions
  localparam int IN_CMD_LSB  = 0;
  localparam int IN_VA_LSB   = IN_CMD_LSB + CMD_W;
  localparam int IN_FA_LSB   = IN_VA_LSB + VA_W;
  localparam int IN_FL_LSB   = IN_FA_LSB + VA_W;

  // Output field positions
  localparam int OUT_PA_LSB    = 0;
  localparam int OUT_FOUND_BIT = OUT_PA_LSB + VA_W;
  localparam int OUT_FL_LSB    = OUT_FOUND_BIT + 1;
  localparam int OUT_USER_BIT  = OUT_FL_LSB + FLAG_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2
  } cmd_t;

endpackage

>>> rtl/core/two_level_page_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table
// Two-level 4 KiB page table engine: map, unmap and translate requests on a
// 32-bit virtual address space, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* carries requests (command, virtual address, frame, flags); out_*
//    carries one result per request (physical address, found, entry flags,
//    directory user bit).
//  - Directory marks (1024 x 2) and table entries (1M x 32, indexed by
//    address bits 31:12) live in two synchronous RAMs. A request reads both
//    in its accept cycle; the modify stage then writes back and loads the
//    result register.
//  - Throughput: one request per cycle when the receiver does not stall. A
//    request that hits the entry written in the same cycle as its read takes
//    the written value from a one-deep bypass register.
//  - Reset: after rst_n rises a clearing pass zeroes every table entry, one
//    per cycle, and the directory along with it, while in_tready stays low.
//  - Receiver stall: the result register holds; one more request may sit in
//    the read stage, then in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
module two_level_page_table
  import tpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // command[1:0], virtual_address[33:2], frame_address[65:34],
  // map_flags[77:66], zero pad[79:78]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // physical_address[31:0], found[32], entry_flags[44:33],
  // directory_user[45], zero pad[47:46]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // --------------------------------------------------------------------------
  // Request field decode
  // --------------------------------------------------------------------------
  logic [VA_W-1:0]   in_va;
  logic [SLOT_W-1:0] in_slot;
  logic              in_fire;

  assign in_va   = in_tdata[IN_VA_LSB +: VA_W];
  assign in_slot = in_va[VA_W-1 -: SLOT_W];
  assign in_fire = in_tvalid & in_tready;

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic              clr_busy_r, clr_busy_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + SLOT_W'(1);
      if (&clr_idx_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Read stage registers
  // --------------------------------------------------------------------------
  logic                s1_valid_r;
  cmd_t                s1_cmd_r;
  logic [VA_W-1:0]     s1_va_r;
  logic [FRAME_W-1:0]  s1_frame_r;
  logic [FLAG_W-1:0]   s1_flags_r;
  logic                fwd_dir_hit_r, fwd_tbl_hit_r;
  logic [DIR_W-1:0]    fwd_dir_r;
  logic [ENTRY_W-1:0]  fwd_tbl_r;

  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic advance, s1_fire;

  assign advance   = ~out_valid_r | out_tready;
  assign s1_fire   = s1_valid_r & advance;
  assign in_tready = ~clr_busy_r & (~s1_valid_r | advance);

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic                 dir_we, tbl_we;
  logic [DIR_IDX_W-1:0] dir_waddr;
  logic [SLOT_W-1:0]    tbl_waddr;
  logic [DIR_W-1:0]     dir_wdata, dir_rdata;
  logic [ENTRY_W-1:0]   tbl_wdata, tbl_rdata;

  tpt_ram #(.DATA_W(DIR_W), .ADDR_W(DIR_IDX_W)) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_we),
    .wr_addr (dir_waddr),
    .wr_data (dir_wdata),
    .rd_en   (in_fire),
    .rd_addr (in_slot[SLOT_W-1 -: DIR_IDX_W]),
    .rd_data (dir_rdata)
  );

  tpt_ram #(.DATA_W(ENTRY_W), .ADDR_W(SLOT_W)) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (in_fire),
    .rd_addr (in_slot),
    .rd_data (tbl_rdata)
  );

  // --------------------------------------------------------------------------
  // Modify stage: bypass, update and result
  // --------------------------------------------------------------------------
  logic [DIR_W-1:0]    dir_cur, dir_new;
  logic [ENTRY_W-1:0]  tbl_cur, tbl_new;
  logic                dir_present, dir_user, user_out;
  logic                map_dir_we, map_tbl_we;
  logic                hit;
  logic [VA_W-1:0]     pa;
  logic [FLAG_W-1:0]   eflags;

  assign dir_cur     = fwd_dir_hit_r ? fwd_dir_r : dir_rdata;
  assign tbl_cur     = fwd_tbl_hit_r ? fwd_tbl_r : tbl_rdata;
  assign dir_present = dir_cur[DIR_PRESENT_BIT];
  assign dir_user    = dir_cur[DIR_USER_BIT];

  always_comb begin
    dir_new    = dir_cur;
    tbl_new    = '0;
    map_dir_we = 1'b0;
    map_tbl_we = 1'b0;
    hit        = 1'b0;
    pa         = '0;
    eflags     = '0;
    user_out   = dir_user;
    unique case (s1_cmd_r)
      CMD_MAP: begin
        // new directory takes the user flag; present one only gains it
        dir_new[DIR_PRESENT_BIT] = 1'b1;
        dir_new[DIR_USER_BIT]    = s1_flags_r[FLAG_USER_BIT] | (dir_present & dir_user);
        tbl_new    = {s1_frame_r, s1_flags_r | FLAG_W'(1)};
        map_dir_we = 1'b1;
        map_tbl_we = 1'b1;
        user_out   = dir_new[DIR_USER_BIT];
      end
      CMD_UNMAP: begin
        map_tbl_we = dir_present;
      end
      CMD_XLATE: begin
        hit = dir_present & tbl_cur[FLAG_PRESENT_BIT];
        if (hit) begin
          pa     = {tbl_cur[ENTRY_W-1 -: FRAME_W], s1_va_r[OFFSET_W-1:0]};
          eflags = tbl_cur[FLAG_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Write port muxing: clearing pass or modify stage
  always_comb begin
    if (clr_busy_r) begin
      dir_we    = 1'b1;
      dir_waddr = clr_idx_r[DIR_IDX_W-1:0];
      dir_wdata = '0;
      tbl_we    = 1'b1;
      tbl_waddr = clr_idx_r;
      tbl_wdata = '0;
    end else begin
      dir_we    = s1_fire & map_dir_we;
      dir_waddr = s1_va_r[VA_W-1 -: DIR_IDX_W];
      dir_wdata = dir_new;
      tbl_we    = s1_fire & map_tbl_we;
      tbl_waddr = s1_va_r[VA_W-1 -: SLOT_W];
      tbl_wdata = tbl_new;
    end
  end

  // --------------------------------------------------------------------------
  // Stage and output registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Request payload plus bypass of the write landing in the read cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r      <= cmd_t'(in_tdata[IN_CMD_LSB +: CMD_W]);
      s1_va_r       <= in_va;
      s1_frame_r    <= in_tdata[IN_FA_LSB + OFFSET_W +: FRAME_W];
      s1_flags_r    <= in_tdata[IN_FL_LSB +: FLAG_W];
      fwd_dir_hit_r <= dir_we & (dir_waddr == in_slot[SLOT_W-1 -: DIR_IDX_W]);
      fwd_dir_r     <= dir_wdata;
      fwd_tbl_hit_r <= tbl_we & (tbl_waddr == in_slot);
      fwd_tbl_r     <= tbl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {2'b00, user_out, eflags, hit, pa};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/core/tpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read (old data on a same-address write).
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/tpt_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_chk
// Port-level checker for the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_chk
  import tpt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic found;
  assign found = out_tdata[OUT_FOUND_BIT];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset starts the clearing pass: no requests taken, no results shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("engine active right after reset");

  // A hit always reports a present table entry
  a_hit_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && found |-> out_tdata[OUT_FL_LSB + FLAG_PRESENT_BIT])
    else $error("hit without present flag");

  // A miss reports zero address and flags
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !found |->
      out_tdata[OUT_PA_LSB +: VA_W] == '0 && out_tdata[OUT_FL_LSB +: FLAG_W] == '0)
    else $error("miss with nonzero address or flags");

  // A result never shows without a request taken earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without request");

endmodule

bind two_level_page_table tpt_chk u_tpt_chk (.*);

>>> tb/two_level_page_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_tb
// Streams map, unmap and translate requests into the page table engine and
// checks every result against a shadow copy of the directory and the page
// table. A short directed sequence covers the corner cases. Random traffic
// then works a small pool of pages so that most translates hit live
// entries. Both sides idle at random, and the receiver stalls once for a
// long stretch to back the engine up.
// ----------------------------------------------------------------------------
module two_level_page_table_tb;
  import tpt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IN_PAD_W        = IN_TDATA_W - CMD_W - 2 * VA_W - FLAG_W;
  localparam int RANDOM_REQUESTS = 1650;
  localparam int HOLD_OFF_AT     = 300;    // result count where the long stall starts
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 10;
  // clearing pass after reset plus generous room for the traffic itself
  localparam int CYCLE_LIMIT     = (1 << SLOT_W) + 200_000;

  typedef struct packed {
    logic [VA_W-1:0]   pa;
    logic              found;
    logic [FLAG_W-1:0] flags;
    logic              user;
  } xlate_result_t;

  // Shadow page table and the results still owed by the engine
  class page_table_scoreboard;
    bit [DIR_W-1:0]   dir_marks [1 << DIR_IDX_W];
    bit [ENTRY_W-1:0] table_mem [1 << SLOT_W];
    xlate_result_t    pending_results [$];
    int               error_count;

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
    endtask

    // Apply one accepted request to the shadow state, queue its result
    function void note_request(logic [IN_TDATA_W-1:0] req);
      logic [CMD_W-1:0]     cmd;
      logic [VA_W-1:0]      va;
      logic [VA_W-1:0]      fa;
      logic [FLAG_W-1:0]    fl;
      logic [DIR_IDX_W-1:0] di;
      logic [SLOT_W-1:0]    slot;
      bit [DIR_W-1:0]       mark;
      bit [ENTRY_W-1:0]     entry;
      xlate_result_t        res;
      cmd  = req[IN_CMD_LSB +: CMD_W];
      va   = req[IN_VA_LSB +: VA_W];
      fa   = req[IN_FA_LSB +: VA_W];
      fl   = req[IN_FL_LSB +: FLAG_W];
      di   = va[VA_W-1 -: DIR_IDX_W];
      slot = va[VA_W-1 -: SLOT_W];
      mark = dir_marks[di];
      res  = '0;
      case (cmd)
        CMD_MAP: begin
          // new directory entry takes the user bit; an existing one only gains it
          if (!mark[DIR_PRESENT_BIT]) begin
            mark = '0;
            mark[DIR_PRESENT_BIT] = 1'b1;
            mark[DIR_USER_BIT]    = fl[FLAG_USER_BIT];
          end else if (fl[FLAG_USER_BIT]) begin
            mark[DIR_USER_BIT] = 1'b1;
          end
          dir_marks[di] = mark;
          entry = {fa[VA_W-1:OFFSET_W], fl};
          entry[FLAG_PRESENT_BIT] = 1'b1;
          table_mem[slot] = entry;
        end
        CMD_UNMAP: begin
          if (mark[DIR_PRESENT_BIT]) table_mem[slot] = '0;
        end
        CMD_XLATE: begin
          entry = table_mem[slot];
          if (mark[DIR_PRESENT_BIT] && entry[FLAG_PRESENT_BIT]) begin
            res.pa    = {entry[ENTRY_W-1:OFFSET_W], va[OFFSET_W-1:0]};
            res.found = 1'b1;
            res.flags = entry[FLAG_W-1:0];
          end
        end
        default: ;
      endcase
      res.user = dir_marks[di][DIR_USER_BIT];
      pending_results.push_back(res);
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] rsp);
      xlate_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h with no request pending", rsp));
        return;
      end
      want = pending_results.pop_front();
      if (rsp[OUT_PA_LSB +: VA_W] !== want.pa)
        report($sformatf("physical_address %h, expected %h",
                         rsp[OUT_PA_LSB +: VA_W], want.pa));
      if (rsp[OUT_FOUND_BIT] !== want.found)
        report($sformatf("found %b, expected %b", rsp[OUT_FOUND_BIT], want.found));
      if (rsp[OUT_FL_LSB +: FLAG_W] !== want.flags)
        report($sformatf("entry_flags %h, expected %h",
                         rsp[OUT_FL_LSB +: FLAG_W], want.flags));
      if (rsp[OUT_USER_BIT] !== want.user)
        report($sformatf("directory_user %b, expected %b", rsp[OUT_USER_BIT], want.user));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  page_table_scoreboard pt_book = new();

  logic [DIR_IDX_W-1:0] dir_pool [6];
  logic [TBL_IDX_W-1:0] tbl_pool [8];
  bit                   send_busy;
  int                   send_count;
  int                   cycle_count;

  two_level_page_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Observe both handshakes
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) pt_book.note_request(in_tdata);
    if (rst_n && out_tvalid && out_tready) pt_book.check_result(out_tdata);
  end

  // Offer one request after a random gap and hold it until accepted
  task send_request(logic [CMD_W-1:0] cmd, logic [VA_W-1:0] va,
                    logic [VA_W-1:0] fa, logic [FLAG_W-1:0] fl);
    int gap;
    if (send_count % 50 == 0) send_busy = $urandom_range(0, 3) != 0;
    gap = send_busy ? $urandom_range(0, 4) : 0;
    send_count++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, fl, fa, va, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Result side: random gaps, quiet stretches, one long hold-off
  initial begin : result_sink
    int gap;
    int taken;
    bit busy;
    wait (rst_n);
    forever begin
      if (taken % 64 == 0) busy = $urandom_range(0, 3) != 0;
      gap = busy ? $urandom_range(0, 4) : 0;
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : main_flow
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [VA_W-1:0]  va;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: misses on an empty table
    send_request(CMD_XLATE,  32'h0000_0000, 32'h0,         12'h000);
    send_request(CMD_XLATE,  32'hFFFF_FFFF, 32'h0,         12'h000);
    send_request(CMD_UNMAP,  32'h0040_0000, 32'h0,         12'h000);
    send_request(CMD_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    // extremes of frame, flags and address
    send_request(CMD_MAP,    32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    send_request(CMD_XLATE,  32'h0000_0FFF, 32'h0,         12'h000);
    send_request(CMD_MAP,    32'hFFFF_F123, 32'h0000_0000, 12'h000);
    send_request(CMD_XLATE,  32'hFFFF_FFFF, 32'h0,         12'h000);
    // present directory, absent table entry
    send_request(CMD_XLATE,  32'hFFC0_0000, 32'h0,         12'h000);
    // existing directory entry gains the user bit, never loses it
    send_request(CMD_MAP,    32'hFFC0_0000, 32'h1234_5000, 12'h004);
    send_request(CMD_XLATE,  32'hFFC0_0ABC, 32'h0,         12'h000);
    send_request(CMD_MAP,    32'hFFFF_F000, 32'hABCD_E000, 12'h002);
    send_request(CMD_XLATE,  32'hFFFF_F000, 32'h0,         12'h000);
    // unmap in a present directory, then again
    send_request(CMD_UNMAP,  32'hFFFF_F000, 32'h0,         12'h000);
    send_request(CMD_XLATE,  32'hFFFF_F000, 32'h0,         12'h000);
    send_request(CMD_UNMAP,  32'hFFFF_F000, 32'h0,         12'h000);
    send_request(CMD_UNUSED, 32'hFFC0_0000, 32'h0,         12'h000);
    // first map into a directory sets user right away
    send_request(CMD_MAP,    32'h0080_0000, 32'h5555_5555, 12'h005);
    send_request(CMD_XLATE,  32'h0080_0555, 32'h0,         12'h000);
    // flags without the present bit still yield a present entry
    send_request(CMD_MAP,    32'h0080_0000, 32'hAAAA_AAAA, 12'hAAA);
    send_request(CMD_XLATE,  32'h0080_0000, 32'h0,         12'h000);
    send_request(CMD_MAP,    32'h0000_0000, 32'h0000_0000, 12'h000);
    send_request(CMD_XLATE,  32'h0000_0000, 32'h0,         12'h000);

    // random: mostly a small set of pages so translates hit live entries
    dir_pool[0] = '0;
    dir_pool[1] = '1;
    for (int d = 2; d < 6; d++) dir_pool[d] = DIR_IDX_W'($urandom);
    tbl_pool[0] = '0;
    tbl_pool[1] = '1;
    for (int t = 2; t < 8; t++) tbl_pool[t] = TBL_IDX_W'($urandom);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_MAP;
      else if (pick < 55) cmd = CMD_UNMAP;
      else if (pick < 95) cmd = CMD_XLATE;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 3) != 0)
        va = {dir_pool[$urandom_range(0, 5)], tbl_pool[$urandom_range(0, 7)],
              OFFSET_W'($urandom)};
      else
        va = $urandom;
      send_request(cmd, va, $urandom, FLAG_W'($urandom));
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then a short tail
    @(posedge clk);
    while (pt_book.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pt_book.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
